// File: rtl/macad_pkg.sv
// shared types, constants and the mux code lookup for the accumulate and dump unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package macad_pkg;

  localparam int SAMPLE_W = 12;
  localparam int CODE_W = 5;
  localparam int IDX_OUT_W = 3;
  localparam int OUT_SUM_W = 32;
  localparam int CFG_W = 16;
  localparam int IN_TDATA_W = 16;
  localparam int OUT_TDATA_W = 40;

  localparam int MUX_TABLE_SIZE = 5;
  localparam logic [CODE_W-1:0] FINAL_MUX_CODE = 5'h11;
  localparam logic [CODE_W-1:0] MUX_TABLE [MUX_TABLE_SIZE] = '{5'd0, 5'd1, 5'd3, 5'd7, 5'd8};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_DLOAD,
    ST_DSEND
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_dump;
  } dp_cmd_t;

  typedef struct packed {
    logic dump_due;
    logic out_last;
  } dp_status_t;

  function automatic logic [CODE_W-1:0] mux_code(input logic [3:0] pos);
    logic [CODE_W-1:0] code;
    if (pos < 4'(MUX_TABLE_SIZE)) begin
      code = MUX_TABLE[pos[2:0]];
    end else begin
      code = FINAL_MUX_CODE;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// File: rtl/macad_dp.sv
// datapath: slot accumulators, round counter, dump index and output register
// depends on macad_pkg
`timescale 1ns / 1ps
`default_nettype none

module macad_dp #(
  parameter int LAST_SLOT = 5,
  parameter int SUM_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  macad_pkg::dp_cmd_t                   cmd,
  output macad_pkg::dp_status_t                status,
  input  logic [macad_pkg::SAMPLE_W-1:0]       sample,
  input  logic                                 cfg_we,
  input  logic [macad_pkg::CFG_W-1:0]          cfg_data,
  output logic [macad_pkg::CODE_W-1:0]         out_code,
  output logic                                 out_dump,
  output logic [macad_pkg::IDX_OUT_W-1:0]      out_idx,
  output logic [macad_pkg::OUT_SUM_W-1:0]      out_sum,
  output logic                                 out_last
);

  localparam int SLOT_CNT = LAST_SLOT + 1;
  localparam int IDX_W = $clog2(SLOT_CNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LAST_SLOT);
  localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

  logic [SUM_BITS-1:0]           acc [SLOT_CNT];
  logic [IDX_W-1:0]              slot_pos;
  logic [IDX_W-1:0]              dump_idx;
  logic [macad_pkg::CFG_W-1:0]   round_cnt;
  logic [macad_pkg::CFG_W-1:0]   rounds_per_dump;

  logic [IDX_W-1:0]              rd_addr;
  logic [SUM_BITS-1:0]           rd_acc;
  logic [SUM_BITS:0]             sum_wide;
  logic [SUM_BITS-1:0]           acc_sat;
  logic [macad_pkg::CFG_W:0]     round_next;
  logic                          dump_due;
  logic [15:0]                   idx_ext;
  logic [63:0]                   sum_ext;

  always_comb begin
    rd_addr = cmd.load_dump ? dump_idx : slot_pos;
    rd_acc = acc[rd_addr];
    sum_wide = {1'b0, rd_acc} + (SUM_BITS + 1)'(sample);
    acc_sat = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
    round_next = {1'b0, round_cnt} + (macad_pkg::CFG_W + 1)'(1);
    dump_due = (slot_pos == LAST_IDX) && !(round_next < {1'b0, rounds_per_dump});
    idx_ext = 16'(dump_idx);
    sum_ext = 64'(rd_acc);
  end

  assign status.dump_due = dump_due;
  assign status.out_last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '{default: '0};
      slot_pos <= '0;
      dump_idx <= '0;
      round_cnt <= '0;
      rounds_per_dump <= macad_pkg::CFG_W'(1);
    end else begin
      if (cfg_we) begin
        rounds_per_dump <= cfg_data;
      end
      if (cmd.accept) begin
        acc[slot_pos] <= acc_sat;
        dump_idx <= '0;
        if (slot_pos == LAST_IDX) begin
          slot_pos <= '0;
          round_cnt <= dump_due ? '0 : round_next[macad_pkg::CFG_W-1:0];
        end else begin
          slot_pos <= slot_pos + 1'b1;
        end
      end else if (cmd.load_dump) begin
        acc[dump_idx] <= '0;
        dump_idx <= dump_idx + 1'b1;
      end
    end
  end

  // output register, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      out_code <= macad_pkg::mux_code(4'(slot_pos));
      out_dump <= 1'b0;
      out_idx <= '0;
      out_sum <= '0;
      out_last <= 1'b1;
    end else if (cmd.load_dump) begin
      out_dump <= 1'b1;
      out_idx <= idx_ext[macad_pkg::IDX_OUT_W-1:0];
      out_sum <= sum_ext[macad_pkg::OUT_SUM_W-1:0];
      out_last <= (dump_idx == LAST_IDX);
    end
  end

endmodule

`default_nettype wire

// File: rtl/macad_ctrl.sv
// controller state machine: input and output handshakes, dump sequencing
// depends on macad_pkg
`timescale 1ns / 1ps
`default_nettype none

module macad_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_valid,
  output logic                  s_ready,
  output logic                  m_valid,
  input  logic                  m_ready,
  input  macad_pkg::dp_status_t status,
  output macad_pkg::dp_cmd_t    cmd
);

  macad_pkg::state_t state;
  macad_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= macad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      macad_pkg::ST_IDLE: begin
        if (s_valid) begin
          state_next = status.dump_due ? macad_pkg::ST_DLOAD : macad_pkg::ST_SEND;
        end
      end
      macad_pkg::ST_SEND: begin
        if (m_ready) begin
          if (s_valid) begin
            state_next = status.dump_due ? macad_pkg::ST_DLOAD : macad_pkg::ST_SEND;
          end else begin
            state_next = macad_pkg::ST_IDLE;
          end
        end
      end
      macad_pkg::ST_DLOAD: begin
        state_next = macad_pkg::ST_DSEND;
      end
      macad_pkg::ST_DSEND: begin
        if (m_ready && status.out_last) begin
          state_next = macad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = macad_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_ready = 1'b0;
    m_valid = 1'b0;
    cmd.load_dump = 1'b0;
    case (state)
      macad_pkg::ST_IDLE: begin
        s_ready = 1'b1;
      end
      macad_pkg::ST_SEND: begin
        m_valid = 1'b1;
        s_ready = m_ready;
      end
      macad_pkg::ST_DLOAD: begin
        cmd.load_dump = 1'b1;
      end
      macad_pkg::ST_DSEND: begin
        m_valid = 1'b1;
        cmd.load_dump = m_ready && !status.out_last;
      end
      default: begin
        s_ready = 1'b0;
      end
    endcase
    cmd.accept = s_valid && s_ready;
  end

endmodule

`default_nettype wire

// File: rtl/multichannel_adc_accumulate_dump_unit.sv
// top level of the multichannel adc accumulate and dump unit
// depends on macad_pkg, macad_ctrl and macad_dp
`timescale 1ns / 1ps
`default_nettype none

// Each sample accepted on the s_axis side is added, saturating at 2^SUM_BITS-1, to the
// accumulator of the current slot; slots 0..LAST_SLOT are visited round robin. Every sample
// yields the mux code for the next conversion. An ordinary sample gives one result with
// tuser low; a new sample is taken in the same cycle that result is taken, so the plain
// path runs at one sample per cycle while m_axis_tready is high. When the last slot
// completes the configured number of rounds, the ST_DLOAD state loads the first slot sum,
// then LAST_SLOT+1 results with tuser high follow (slot 0 first, tlast on the last) at one
// per cycle while m_axis_tready is high and input is held off; the accumulators share one
// read port, which sets this one-sum-per-cycle dump. Accumulators clear to zero at reset.
// rounds_per_dump (reset 1) is written on the always-ready cfg channel; zero acts as one.

module multichannel_adc_accumulate_dump_unit #(
  parameter int LAST_SLOT = 5,
  parameter int SUM_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [macad_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // sample[11:0], upper bits ignored
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [macad_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // next_mux_code, slot_index, slot_sum
  output logic                                  m_axis_tuser,  // dump_valid
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [macad_pkg::CFG_W-1:0]           cfg_data
);

  macad_pkg::dp_cmd_t    cmd;
  macad_pkg::dp_status_t status;

  logic [macad_pkg::CODE_W-1:0]    out_code;
  logic [macad_pkg::IDX_OUT_W-1:0] out_idx;
  logic [macad_pkg::OUT_SUM_W-1:0] out_sum;

  assign cfg_ready = 1'b1;
  assign m_axis_tdata = {out_sum, out_idx, out_code};

  macad_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .status  (status),
    .cmd     (cmd)
  );

  macad_dp #(
    .LAST_SLOT (LAST_SLOT),
    .SUM_BITS  (SUM_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .sample   (s_axis_tdata[macad_pkg::SAMPLE_W-1:0]),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_code (out_code),
    .out_dump (m_axis_tuser),
    .out_idx  (out_idx),
    .out_sum  (out_sum),
    .out_last (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_no_input_during_dump: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> !s_axis_tready)
    else $error("input accepted during dump");

  a_dump_last_slot: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser && m_axis_tlast) |->
      (m_axis_tdata[7:5] == 3'(LAST_SLOT)))
    else $error("dump ended on wrong slot");

  a_plain_result_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
    else $error("plain result without tlast");

  a_dump_end_idle: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && m_axis_tuser && m_axis_tlast) |=> !m_axis_tvalid)
    else $error("output valid right after dump end");
`endif

endmodule

`default_nettype wire

// File: tb/multichannel_adc_accumulate_dump_unit_test.sv
// testbench for the multichannel adc accumulate and dump unit: directed and random samples,
// an in-line predictor of slot sums, mux codes and dumps, and checks of every result
// depends on macad_pkg and multichannel_adc_accumulate_dump_unit
`timescale 1ns / 1ps

module multichannel_adc_accumulate_dump_unit_test;

  localparam int NUM_SLOTS = 6;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 40;
  localparam logic [macad_pkg::CODE_W-1:0] CODE_LAST_SLOT = 5'h11;
  localparam logic [macad_pkg::CODE_W-1:0] SLOT_CODES [5] =
    '{5'd0, 5'd1, 5'd3, 5'd7, 5'd8};

  typedef struct {
    logic [macad_pkg::CODE_W-1:0]    code;
    logic                            dump;
    logic [macad_pkg::IDX_OUT_W-1:0] idx;
    logic [macad_pkg::OUT_SUM_W-1:0] sum;
    logic                            last;
  } slot_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [macad_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [macad_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [macad_pkg::CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic [macad_pkg::CFG_W-1:0] rounds_cfg = 16'd1;
  logic [2:0] slot_at = '0;
  logic [16:0] round_at = '0;
  logic [macad_pkg::OUT_SUM_W-1:0] slot_sums [NUM_SLOTS] = '{default: '0};

  logic [macad_pkg::IN_TDATA_W-1:0] pending_samples [$];
  slot_result_t expected_results [$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  logic in_fire = 1'b0;

  multichannel_adc_accumulate_dump_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  function automatic logic [macad_pkg::CODE_W-1:0] code_after(input logic [2:0] pos);
    if (pos < 3'd5) begin
      return SLOT_CODES[pos];
    end
    return CODE_LAST_SLOT;
  endfunction

  function automatic void accumulate_sample(input logic [macad_pkg::IN_TDATA_W-1:0] word);
    logic [macad_pkg::OUT_SUM_W:0] total;
    logic [macad_pkg::CODE_W-1:0] code;
    logic [16:0] next_round;
    slot_result_t r;
    total = {1'b0, slot_sums[slot_at]}
          + (macad_pkg::OUT_SUM_W+1)'(word[macad_pkg::SAMPLE_W-1:0]);
    slot_sums[slot_at] = total[macad_pkg::OUT_SUM_W] ? '1
                                                     : total[macad_pkg::OUT_SUM_W-1:0];
    code = code_after(slot_at);
    r.code = code;
    if (slot_at < 3'(NUM_SLOTS - 1)) begin
      slot_at = slot_at + 3'd1;
    end else begin
      slot_at = '0;
      next_round = round_at + 17'd1;
      if (next_round < {1'b0, rounds_cfg}) begin
        round_at = next_round;
      end else begin
        round_at = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          r.dump = 1'b1;
          r.idx = 3'(i);
          r.sum = slot_sums[i];
          r.last = (i == NUM_SLOTS - 1);
          expected_results.push_back(r);
          slot_sums[i] = '0;
        end
        return;
      end
    end
    r.dump = 1'b0;
    r.idx = '0;
    r.sum = '0;
    r.last = 1'b1;
    expected_results.push_back(r);
  endfunction

  // monitor: results first, then the sample taken at this edge
  always @(posedge clk) begin
    slot_result_t exp_r;
    in_fire = 1'b0;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_axis_tdata[4:0] !== exp_r.code) begin
            $error("next_mux_code expected %0d got %0d", exp_r.code, m_axis_tdata[4:0]);
            errors++;
          end
          if (m_axis_tuser !== exp_r.dump) begin
            $error("dump_valid expected %0d got %0d", exp_r.dump, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[7:5] !== exp_r.idx) begin
            $error("slot_index expected %0d got %0d", exp_r.idx, m_axis_tdata[7:5]);
            errors++;
          end
          if (m_axis_tdata[39:8] !== exp_r.sum) begin
            $error("slot_sum expected %0d got %0d", exp_r.sum, m_axis_tdata[39:8]);
            errors++;
          end
          if (m_axis_tlast !== exp_r.last) begin
            $error("last expected %0d got %0d", exp_r.last, m_axis_tlast);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        in_fire = 1'b1;
        accumulate_sample(s_axis_tdata);
      end
      if (cfg_valid && cfg_ready) begin
        rounds_cfg = cfg_data;
      end
      if (in_fire || (m_axis_tvalid && m_axis_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tdata <= pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_samples.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_rounds(input logic [macad_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [macad_pkg::IN_TDATA_W-1:0] word;
    int phase_rounds [5];
    int phase_idle [5];
    int phase_stall [5];
    phase_rounds = '{2, 1, 3, 0, 4};
    phase_idle = '{0, 67, 0, 17, 0};
    phase_stall = '{0, 0, 67, 17, 0};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // extremes and ignored upper tdata bits, two dumps at the reset count of one
    pending_samples = '{16'h0000, 16'h0fff, 16'h0001, 16'h0800, 16'h07ff, 16'h0555,
                        16'hfaaa, 16'h8fff, 16'h0fff, 16'h0000, 16'h7123, 16'h0ffe};
    wait_drained();
    // zero count behaves as one
    write_rounds(16'd0);
    repeat (6) pending_samples.push_back(16'h0fff);
    wait_drained();
    // largest count, then lowered mid-accumulation so the next round end dumps
    write_rounds(16'hffff);
    repeat (8) pending_samples.push_back(16'h0abc);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      write_rounds(16'(phase_rounds[p]));
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        case ($urandom_range(7))
          0: word = 16'h0000;
          1: word = 16'h0fff;
          default: word = 16'($urandom_range(4095));
        endcase
        pending_samples.push_back(word);
      end
      wait_drained();
    end

    send_idle_pct = 0;
    stall_pct = 0;
    repeat (10) @(posedge clk);
    #1;
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
